// ----- src/idea_cbc_mac_engine_unit_macros.svh -----
// Assertion macros shared by the IDEA CBC-MAC engine RTL.
`ifndef IDEA_CBC_MAC_ENGINE_UNIT_MACROS_SVH
`define IDEA_CBC_MAC_ENGINE_UNIT_MACROS_SVH
// Check a property while out of reset.
`define IDEA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define IDEA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

// ----- src/idea_cme_pkg.sv -----
// Shared types, constants and key schedule function of the IDEA CBC-MAC engine.
package idea_cme_pkg;
    localparam int unsigned BLOCK_W   = 64;
    localparam int unsigned KEY_W     = 128;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned SKEY_IDX_W = 6;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned ROUNDS    = 8;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;
    localparam logic [BLOCK_W-1:0]   PAD_BLOCK    = 64'h0100_0000_0000_0000;
    localparam logic                 ST_OK        = 1'b0;
    localparam logic                 ST_SHORT     = 1'b1;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [KEY_W-1:0]   t_key;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    // Subkey idx: group idx/8 is the key rotated left by 25 per group.
    function automatic t_word subkey(input t_key key, input logic [SKEY_IDX_W-1:0] idx);
        t_key        rk;
        logic [6:0]  sh;
        case (idx[5:3])
            3'd0:    rk = key;
            3'd1:    rk = {key[102:0], key[127:103]};
            3'd2:    rk = {key[77:0],  key[127:78]};
            3'd3:    rk = {key[52:0],  key[127:53]};
            3'd4:    rk = {key[27:0],  key[127:28]};
            3'd5:    rk = {key[2:0],   key[127:3]};
            default: rk = {key[105:0], key[127:106]};
        endcase
        sh = {(3'd7 - idx[2:0]), 4'd0};
        return t_word'(rk >> sh);
    endfunction
endpackage

// ----- src/idea_cme_if.sv -----
// Valid/ready channel interfaces: input blocks, MAC results, configuration writes.
interface idea_cme_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_data;
    logic [3:0]  byte_count;
    logic        first_of_message;
    logic        last_of_message;
    modport source (output valid, block_data, byte_count, first_of_message, last_of_message,
                    input ready);
    modport sink   (input valid, block_data, byte_count, first_of_message, last_of_message,
                    output ready);
endinterface

interface idea_cme_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] mac;
    logic        status;
    modport source (output valid, mac, status, input ready);
    modport sink   (input valid, mac, status, output ready);
endinterface

interface idea_cme_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/idea_cme_mul.sv -----
// Multiplier modulo 65537 with zero standing for 65536.
module idea_cme_mul (
    input  idea_cme_pkg::t_word i_a,
    input  idea_cme_pkg::t_word i_b,
    output idea_cme_pkg::t_word o_y
);
    import idea_cme_pkg::*;
    logic [31:0] p;
    t_word       lo, hi;

    assign p  = 32'(i_a) * 32'(i_b);
    assign lo = p[15:0];
    assign hi = p[31:16];

    always_comb begin
        if (i_a == '0) begin
            o_y = 16'd1 - i_b;
        end else if (i_b == '0) begin
            o_y = 16'd1 - i_a;
        end else begin
            o_y = lo - hi + {15'd0, (lo < hi)};
        end
    end
endmodule

// ----- src/idea_cme_core.sv -----
// IDEA block encryption sequenced over one shared modular multiplier.
module idea_cme_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  idea_cme_pkg::t_block       i_block,
    input  idea_cme_pkg::t_key         i_key,
    output idea_cme_pkg::t_block       o_block,
    output idea_cme_pkg::t_core_stat   o_stat
);
    import idea_cme_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL1 = 7'b0000010,
        S_MUL4 = 7'b0000100,
        S_MULA = 7'b0001000,
        S_MULB = 7'b0010000,
        S_OUT1 = 7'b0100000,
        S_OUT4 = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_round, n_round;
    logic       r_done, n_done;
    t_word r_x1, r_x2, r_x3, r_x4, r_t2;
    t_word n_x1, n_x2, n_x3, n_x4, n_t2;
    t_word mul_a, mul_b, mul_y, k, t1, t2n;
    logic [SKEY_IDX_W-1:0] base, idx;

    idea_cme_mul u_mul (.i_a(mul_a), .i_b(mul_b), .o_y(mul_y));

    assign base = {1'b0, r_round, 2'b00} + {2'b00, r_round, 1'b0};

    always_comb begin
        case (r_state)
            S_MUL1:  idx = base;
            S_MUL4:  idx = base + 6'd3;
            S_MULA:  idx = base + 6'd4;
            S_MULB:  idx = base + 6'd5;
            S_OUT1:  idx = 6'd48;
            S_OUT4:  idx = 6'd51;
            default: idx = base;
        endcase
    end

    assign k   = subkey(i_key, idx);
    assign t1  = mul_y;
    assign t2n = t1 + r_t2;

    always_comb begin
        case (r_state)
            S_MUL1, S_OUT1: mul_a = r_x1;
            S_MUL4, S_OUT4: mul_a = r_x4;
            S_MULA:         mul_a = r_x1 ^ r_x3;
            S_MULB:         mul_a = r_t2 + (r_x2 ^ r_x4);
            default:        mul_a = r_x1;
        endcase
        mul_b = k;
    end

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_done  = 1'b0;
        n_x1 = r_x1; n_x2 = r_x2; n_x3 = r_x3; n_x4 = r_x4; n_t2 = r_t2;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    {n_x1, n_x2, n_x3, n_x4} = i_block;
                    n_round = '0;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_x1 = mul_y;
                n_x2 = r_x2 + subkey(i_key, base + 6'd1);
                n_x3 = r_x3 + subkey(i_key, base + 6'd2);
                n_state = S_MUL4;
            end
            S_MUL4: begin
                n_x4 = mul_y;
                n_state = S_MULA;
            end
            S_MULA: begin
                n_t2 = mul_y;
                n_state = S_MULB;
            end
            S_MULB: begin
                n_x1 = r_x1 ^ t1;
                n_x4 = r_x4 ^ t2n;
                n_x2 = r_x3 ^ t1;
                n_x3 = t2n ^ r_x2;
                n_round = r_round + 3'd1;
                n_state = (r_round == 3'(ROUNDS - 1)) ? S_OUT1 : S_MUL1;
            end
            S_OUT1: begin
                // Output transform swaps the middle words.
                n_x1 = mul_y;
                n_x2 = r_x3 + subkey(i_key, 6'd49);
                n_x3 = r_x2 + subkey(i_key, 6'd50);
                n_state = S_OUT4;
            end
            S_OUT4: begin
                n_x4 = mul_y;
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_done  <= n_done;
        end
        r_x1 <= n_x1; r_x2 <= n_x2; r_x3 <= n_x3; r_x4 <= n_x4; r_t2 <= n_t2;
    end

    assign o_block     = {r_x1, r_x2, r_x3, r_x4};
    assign o_stat.done = r_done;
    assign o_stat.busy = (r_state != S_IDLE);
endmodule

// ----- src/idea_cbc_mac_engine_unit.sv -----
// Top level of the IDEA CBC-MAC engine: handshakes, key, chaining and padding.
// Usage:
//   i_in  carries one 8-byte message block per transaction, first byte in the top bits,
//         with its byte count and first/last flags. i_in.ready is high only while the
//         engine is idle; one block is worked on at a time.
//   o_out carries the MAC and a status bit. A result is produced for the last block of
//         a message, and for a short non-last block (status 1, mac 0).
//   i_cfg writes key_high (index 0) or key_low (index 1); other indexes are ignored.
//         Write only while idle; the write is always accepted.
// Sequencing: one encryption runs 8 rounds of 4 steps plus 2 output steps, each step
//   using the single shared modular multiplier. A full non-last block frees the input
//   after its encryption ends; a short last block delivers its MAC after one encryption;
//   a full last block runs a second pad block before its MAC is delivered.
//   A short non-last block is reported without an encryption.
// Reset: key and chaining value clear to zero, no result is pending.
// Stall: the result sits in an output register; if it is still not taken when the next
//   result is ready, the engine holds that result and takes no new block until the
//   output register frees up.
module idea_cbc_mac_engine_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    idea_cme_in_if.sink       i_in,
    idea_cme_out_if.source    o_out,
    idea_cme_cfg_if.sink      i_cfg
);
    import idea_cme_pkg::*;
    `include "idea_cbc_mac_engine_unit_macros.svh"

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_RUN1 = 4'b0010,
        T_RUN2 = 4'b0100,
        T_WAIT = 4'b1000
    } t_top_state;

    t_top_state r_state, n_state;
    logic [63:0] r_key_high, r_key_low;
    t_block      r_cv, n_cv;
    logic        r_last, n_last;
    logic        r_second, n_second;
    t_block      r_res_mac, n_res_mac;
    logic        r_res_st, n_res_st;
    logic        r_out_valid, n_out_valid;
    t_block      r_out_mac, n_out_mac;
    logic        r_out_st, n_out_st;

    logic        core_start;
    t_block      core_in, core_out;
    t_core_stat  core_stat;

    logic        in_fire, out_fire, out_free;
    logic [3:0]  n_bytes;
    t_block      cv_base, keep_mask, pad_bits, last_blk;

    idea_cme_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_block (core_in),
        .i_key   ({r_key_high, r_key_low}),
        .o_block (core_out),
        .o_stat  (core_stat)
    );

    assign i_in.ready  = (r_state == T_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_fire    = r_out_valid && o_out.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    // Clamp the byte count, keep the valid bytes and append the 0x01 marker to a short block.
    assign n_bytes   = i_in.byte_count[3] ? 4'd8 : i_in.byte_count;
    assign keep_mask = ~({BLOCK_W{1'b1}} >> {n_bytes[2:0], 3'b000});
    assign pad_bits  = PAD_BLOCK >> {n_bytes[2:0], 3'b000};
    assign last_blk  = (n_bytes == 4'd8) ? i_in.block_data
                                         : ((i_in.block_data & keep_mask) | pad_bits);
    assign cv_base   = i_in.first_of_message ? '0 : r_cv;

    always_comb begin
        n_state     = r_state;
        n_cv        = r_cv;
        n_last      = r_last;
        n_second    = r_second;
        n_res_mac   = r_res_mac;
        n_res_st    = r_res_st;
        n_out_valid = out_fire ? 1'b0 : r_out_valid;
        n_out_mac   = r_out_mac;
        n_out_st    = r_out_st;
        core_start  = 1'b0;
        core_in     = cv_base ^ last_blk;
        case (r_state)
            T_IDLE: begin
                if (in_fire) begin
                    n_cv = cv_base;
                    if (!i_in.last_of_message && (n_bytes != 4'd8)) begin
                        // Short block in mid message: report and drop it.
                        n_res_mac = '0;
                        n_res_st  = ST_SHORT;
                        n_state   = T_WAIT;
                    end else begin
                        core_start = 1'b1;
                        n_last     = i_in.last_of_message;
                        n_second   = i_in.last_of_message && (n_bytes == 4'd8);
                        n_state    = T_RUN1;
                    end
                end
            end
            T_RUN1: begin
                if (core_stat.done) begin
                    n_cv = core_out;
                    if (r_second) begin
                        // Full last block: run the extra pad block.
                        core_start = 1'b1;
                        core_in    = core_out ^ PAD_BLOCK;
                        n_second   = 1'b0;
                        n_state    = T_RUN2;
                    end else if (r_last) begin
                        n_res_mac = core_out;
                        n_res_st  = ST_OK;
                        n_state   = T_WAIT;
                    end else begin
                        n_state = T_IDLE;
                    end
                end
            end
            T_RUN2: begin
                if (core_stat.done) begin
                    n_cv      = core_out;
                    n_res_mac = core_out;
                    n_res_st  = ST_OK;
                    n_state   = T_WAIT;
                end
            end
            T_WAIT: begin
                // Hold the result until the output register frees up.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_mac   = r_res_mac;
                    n_out_st    = r_res_st;
                    n_state     = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_cv        <= '0;
            r_last      <= 1'b0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cv        <= n_cv;
            r_last      <= n_last;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_KEY_HIGH) begin
                    r_key_high <= i_cfg.data;
                end else if (i_cfg.index == REG_KEY_LOW) begin
                    r_key_low <= i_cfg.data;
                end
            end
        end
        r_res_mac <= n_res_mac;
        r_res_st  <= n_res_st;
        r_out_mac <= n_out_mac;
        r_out_st  <= n_out_st;
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.mac    = r_out_mac;
    assign o_out.status = r_out_st;

    `IDEA_ASSERT(a_done_in_run, core_stat.done |-> (r_state == T_RUN1 || r_state == T_RUN2), "core finished outside a run")
    `IDEA_ASSERT(a_idle_core, (r_state == T_IDLE) |-> !core_stat.busy, "input ready while core busy")
    `IDEA_ASSERT(a_short_zero, (r_out_valid && r_out_st) |-> (r_out_mac == '0), "short-block result carries a MAC")
    `IDEA_ASSERT_ALWAYS(a_rst_clear, $past(!i_rst_n) |-> !r_out_valid, "result valid after reset")
endmodule
